// ===== src/modexp_pkg.sv =====
package modexp_pkg;

   // Widths of the arithmetic inside the block.
   localparam int MOD_WIDTH = 32;
   localparam int EXP_WIDTH = 63;

   // Widths of the ports, fixed by the item formats.
   localparam int BASE_WIDTH    = 63;
   localparam int EXP_IN_WIDTH  = 63;
   localparam int MOD_IN_WIDTH  = 32;
   localparam int RES_WIDTH     = 32;

   // The step counter must hold the longest multiplier, which is the base.
   localparam int COUNT_WIDTH = $clog2(BASE_WIDTH + 1);

   // Width of the partial sum 2r + x, which stays below three times the modulus.
   localparam int SUM_WIDTH = MOD_WIDTH + 2;

   typedef logic [MOD_WIDTH-1:0]   residue_type;
   typedef logic [EXP_WIDTH-1:0]   exp_type;
   typedef logic [BASE_WIDTH-1:0]  mplier_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [SUM_WIDTH-1:0]   sum_type;

   localparam logic DEST_ACC = 1'b0;
   localparam logic DEST_SQ  = 1'b1;

endpackage

// ===== src/modular_exponentiation.sv =====
// Modular exponentiation: power_residue = base_value ** exponent mod modulus.
// A request is taken at a rising edge with start high and busy low; busy then
// stays high until the result has been put out. The result appears on
// rsp_power_residue for exactly one cycle with rsp_valid high, and the receiver
// has no way to hold it off. A new start may be given in that same cycle.
// The base is first reduced by an MSB-first shift and subtract, one base bit a
// cycle. The exponent is then scanned from its low end; every set bit costs a
// multiply of the accumulator, every bit but the last a squaring. Each modular
// multiply is interleaved shift-add-reduce, one multiplier bit a cycle, with a
// control state (ST_STEP) between multiplies. A modulus of zero skips the
// arithmetic and returns 0. One request is in flight at a time. Reset,
// synchronous and active high, returns the block to idle and drops any request
// in progress.
module modular_exponentiation
   import modexp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [BASE_WIDTH-1:0]   req_base_value,
   input  logic [EXP_IN_WIDTH-1:0] req_exponent,
   input  logic [MOD_IN_WIDTH-1:0] req_modulus,
   output logic                    rsp_valid,
   output logic [RES_WIDTH-1:0]    rsp_power_residue
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;

   logic [1:0]  state_ff, state_in;
   residue_type mod_ff, mod_in;
   residue_type acc_ff, acc_in;
   residue_type sq_ff, sq_in;
   residue_type part_ff, part_in;
   residue_type mcand_ff, mcand_in;
   mplier_type  mplier_ff, mplier_in;
   count_type   count_ff, count_in;
   exp_type     exp_ff, exp_in;
   logic        dest_ff, dest_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RES_WIDTH-1:0] rsp_res_ff, rsp_res_in;

   residue_type     req_mod;
   sum_type         step_sum;
   logic [SUM_WIDTH:0] diff_one;
   logic [SUM_WIDTH:0] diff_two;
   residue_type     step_res;

   assign req_mod = req_modulus[MOD_WIDTH-1:0];

   // One step of r = (2r + bit * x) mod m; the sum is below 3m, so at most
   // two moduli come off.
   always_comb begin
      step_sum = {1'b0, part_ff, 1'b0}
               + (mplier_ff[BASE_WIDTH-1] ? {2'b00, mcand_ff} : '0);
      diff_one = {1'b0, step_sum} - {3'b000, mod_ff};
      diff_two = {1'b0, step_sum} - {2'b00, mod_ff, 1'b0};
      priority if (!diff_two[SUM_WIDTH]) begin
         step_res = diff_two[MOD_WIDTH-1:0];
      end else if (!diff_one[SUM_WIDTH]) begin
         step_res = diff_one[MOD_WIDTH-1:0];
      end else begin
         step_res = step_sum[MOD_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      part_in      = part_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      count_in     = count_ff;
      exp_in       = exp_ff;
      dest_in      = dest_ff;
      rsp_valid_in = 1'b0;
      rsp_res_in   = rsp_res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mod_in    = req_mod;
               exp_in    = req_exponent[EXP_WIDTH-1:0];
               part_in   = '0;
               mcand_in  = residue_type'(1);
               mplier_in = req_base_value;
               count_in  = count_type'(BASE_WIDTH);
               dest_in   = DEST_SQ;
               acc_in    = (req_mod == residue_type'(1)) ? '0 : residue_type'(1);
               if (req_mod == '0) begin
                  // No arithmetic is done for a zero modulus; the answer is 0.
                  acc_in   = '0;
                  exp_in   = '0;
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            part_in   = step_res;
            mplier_in = {mplier_ff[BASE_WIDTH-2:0], 1'b0};
            count_in  = count_ff - count_type'(1);
            if (count_ff == count_type'(1)) begin
               if (dest_ff == DEST_SQ) begin
                  sq_in = step_res;
               end else begin
                  acc_in = step_res;
               end
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            part_in  = '0;
            count_in = count_type'(MOD_WIDTH);
            priority if (exp_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = RES_WIDTH'(acc_ff);
               state_in     = ST_IDLE;
            end else if (exp_ff[0]) begin
               // Clearing the bit makes the next pass square instead.
               exp_in    = {exp_ff[EXP_WIDTH-1:1], 1'b0};
               mcand_in  = sq_ff;
               mplier_in = {acc_ff, {(BASE_WIDTH-MOD_WIDTH){1'b0}}};
               dest_in   = DEST_ACC;
               state_in  = ST_MUL;
            end else begin
               exp_in    = {1'b0, exp_ff[EXP_WIDTH-1:1]};
               mcand_in  = sq_ff;
               mplier_in = {sq_ff, {(BASE_WIDTH-MOD_WIDTH){1'b0}}};
               dest_in   = DEST_SQ;
               state_in  = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mod_ff     <= mod_in;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      part_ff    <= part_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      count_ff   <= count_in;
      exp_ff     <= exp_in;
      dest_ff    <= dest_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_power_residue = rsp_res_ff;

endmodule

// ===== tb/sv/tb_modular_exponentiation.sv =====
`timescale 1ns / 1ps

module tb_modular_exponentiation;
   import modexp_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SETTLE_WAIT  = 4300;
   localparam int RANDOM_ITEMS = 80;

   localparam logic [BASE_WIDTH-1:0]   BASE_MAX = '1;
   localparam logic [EXP_IN_WIDTH-1:0] EXP_MAX  = '1;
   localparam logic [MOD_IN_WIDTH-1:0] MOD_MAX  = '1;

   typedef struct {
      logic [BASE_WIDTH-1:0]   base_value;
      logic [EXP_IN_WIDTH-1:0] exponent;
      logic [MOD_IN_WIDTH-1:0] modulus;
      bit                      is_typed;
      residue_type             typed_residue;
   } power_case_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [BASE_WIDTH-1:0]   req_base_value;
   logic [EXP_IN_WIDTH-1:0] req_exponent;
   logic [MOD_IN_WIDTH-1:0] req_modulus;
   logic                    rsp_valid;
   logic [RES_WIDTH-1:0]    rsp_power_residue;

   residue_type pending_residues[$];
   residue_type oldest_residue;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          no_idle = 0;
   power_case_type directed_cases[20];

   modular_exponentiation u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_base_value    (req_base_value),
      .req_exponent      (req_exponent),
      .req_modulus       (req_modulus),
      .rsp_valid         (rsp_valid),
      .rsp_power_residue (rsp_power_residue)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Right-to-left square and multiply; operands stay below 2^32, so every
   // product fits in 64 bits.
   function automatic residue_type expected_power(input logic [BASE_WIDTH-1:0] base_value,
                                                  input logic [EXP_IN_WIDTH-1:0] exponent,
                                                  input logic [MOD_IN_WIDTH-1:0] modulus);
      logic [63:0]          modulus_wide;
      logic [63:0]          accumulator;
      logic [63:0]          square;
      logic [EXP_WIDTH-1:0] bits_left;
      modulus_wide = 64'(modulus[MOD_WIDTH-1:0]);
      if (modulus_wide == 0)
         return '0;
      accumulator = 64'd1 % modulus_wide;
      square      = 64'(base_value) % modulus_wide;
      bits_left   = exponent[EXP_WIDTH-1:0];
      while (bits_left != 0) begin
         if (bits_left[0])
            accumulator = (accumulator * square) % modulus_wide;
         square    = (square * square) % modulus_wide;
         bits_left = bits_left >> 1;
      end
      return residue_type'(accumulator);
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // The block holds start off with busy; the transfer happens at the first
   // edge that sees start high and busy low.
   task automatic send_request(input logic [BASE_WIDTH-1:0] base_value,
                               input logic [EXP_IN_WIDTH-1:0] exponent,
                               input logic [MOD_IN_WIDTH-1:0] modulus,
                               input bit is_typed,
                               input residue_type typed_residue);
      int unsigned gap;
      residue_type expected;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_base_value <= base_value;
      req_exponent   <= exponent;
      req_modulus    <= modulus;
      do @(posedge clock); while (busy);
      expected = is_typed ? typed_residue : expected_power(base_value, exponent, modulus);
      pending_residues = {pending_residues, expected};
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_residues.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_residues.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing pending", rsp_power_residue));
         end else begin
            oldest_residue = pending_residues.pop_front();
            if (rsp_power_residue !== oldest_residue)
               report_mismatch($sformatf("power_residue %0d, expected %0d",
                                         rsp_power_residue, oldest_residue));
         end
      end
   end

   initial begin
      logic [63:0]             raw;
      logic [BASE_WIDTH-1:0]   base_value;
      logic [EXP_IN_WIDTH-1:0] exponent;
      logic [MOD_IN_WIDTH-1:0] modulus;

      reset          = 1'b1;
      start          = 1'b0;
      req_base_value = '0;
      req_exponent   = '0;
      req_modulus    = '0;

      directed_cases = '{
         '{'0,                      '0,                      32'd1,         1'b1, 32'd0},
         '{BASE_MAX,                EXP_MAX,                 32'd1,         1'b1, 32'd0},
         '{63'd5,                   '0,                      32'd7,         1'b1, 32'd1},
         '{BASE_MAX,                '0,                      MOD_MAX,       1'b1, 32'd1},
         '{'0,                      '0,                      32'd2,         1'b1, 32'd1},
         '{'0,                      63'd5,                   32'd13,        1'b1, 32'd0},
         '{63'd2,                   63'd10,                  32'd1000,      1'b1, 32'd24},
         '{63'd3,                   63'd1,                   32'd0,         1'b1, 32'd0},
         '{BASE_MAX,                EXP_MAX,                 32'd0,         1'b1, 32'd0},
         '{'0,                      '0,                      32'd0,         1'b1, 32'd0},
         '{63'd1,                   EXP_MAX,                 MOD_MAX,       1'b1, 32'd1},
         '{63'd4294967294,          63'd2,                   MOD_MAX,       1'b1, 32'd1},
         '{63'd4294967295,          63'd3,                   MOD_MAX,       1'b1, 32'd0},
         '{63'd2,                   63'd31,                  MOD_MAX,       1'b1, 32'h8000_0000},
         '{BASE_MAX,                63'd1,                   32'd2,         1'b1, 32'd1},
         '{BASE_MAX,                EXP_MAX,                 MOD_MAX,       1'b0, 32'd0},
         '{63'd7,                   EXP_MAX,                 32'd4294967291, 1'b0, 32'd0},
         '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 32'd0},
         '{63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 32'h5555_5555, 1'b0, 32'd0},
         '{63'd123456789,           63'h4000_0000_0000_0000, 32'h8000_0000, 1'b0, 32'd0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i])
         send_request(directed_cases[i].base_value, directed_cases[i].exponent,
                      directed_cases[i].modulus, directed_cases[i].is_typed,
                      directed_cases[i].typed_residue);

      // Let the block drain completely before the random part starts.
      wait_for_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 16 == 0)
            no_idle = ($urandom_range(0, 2) == 0);

         case ($urandom_range(0, 9))
            0:       modulus = $urandom_range(0, 2);
            1:       modulus = MOD_MAX - $urandom_range(0, 4);
            default: modulus = $urandom >> $urandom_range(0, 31);
         endcase

         raw = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0:       base_value = 63'(modulus);
            1:       base_value = 63'(modulus) - 63'd1;
            2:       base_value = raw[62:0] >> $urandom_range(0, 62);
            default: base_value = raw[62:0];
         endcase

         // Long exponents take the longest to compute, so most are kept short.
         raw = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0:       exponent = raw[62:0];
            1:       exponent = 63'($urandom_range(0, 3));
            default: exponent = raw[62:0] >> $urandom_range(44, 62);
         endcase

         send_request(base_value, exponent, modulus, 1'b0, '0);
      end

      wait_for_results();
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
